@@ hw/rtl/quoted_bracket_matcher_assert.svh @@
// Assertion macros used by the checker of the quoted bracket matcher.
`ifndef QUOTED_BRACKET_MATCHER_ASSERT_SVH
`define QUOTED_BRACKET_MATCHER_ASSERT_SVH

// Same-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define QBM_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, sampled on i_clk, off while i_rst_n is low.
`define QBM_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) \
        (ante) |=> (cons)) else $error(msg);

`endif

@@ hw/rtl/qbm_pkg.sv @@
package qbm_pkg;

    typedef enum logic [1:0] {
        PH_WAIT = 2'd0,
        PH_SCAN = 2'd1,
        PH_DONE = 2'd2
    } t_phase;

    typedef enum logic [1:0] {
        KIND_ROUND  = 2'd0,
        KIND_SQUARE = 2'd1,
        KIND_CURLY  = 2'd2,
        KIND_ANGLE  = 2'd3
    } t_kind;

    localparam logic [7:0] CH_OPEN_ROUND   = 8'h28; // (
    localparam logic [7:0] CH_CLOSE_ROUND  = 8'h29; // )
    localparam logic [7:0] CH_OPEN_SQUARE  = 8'h5B; // [
    localparam logic [7:0] CH_CLOSE_SQUARE = 8'h5D; // ]
    localparam logic [7:0] CH_OPEN_CURLY   = 8'h7B; // {
    localparam logic [7:0] CH_CLOSE_CURLY  = 8'h7D; // }
    localparam logic [7:0] CH_OPEN_ANGLE   = 8'h3C; // <
    localparam logic [7:0] CH_CLOSE_ANGLE  = 8'h3E; // >
    localparam logic [7:0] CH_DQUOTE       = 8'h22; // "
    localparam logic [7:0] CH_SQUOTE       = 8'h27; // '
    localparam logic [7:0] CH_BACKSLASH    = 8'h5C; // backslash

    function automatic logic [7:0] open_of(input t_kind kind);
        logic [7:0] c;
        unique case (kind)
            KIND_ROUND:  c = CH_OPEN_ROUND;
            KIND_SQUARE: c = CH_OPEN_SQUARE;
            KIND_CURLY:  c = CH_OPEN_CURLY;
            KIND_ANGLE:  c = CH_OPEN_ANGLE;
            default:     c = CH_OPEN_ROUND;
        endcase
        return c;
    endfunction

    function automatic logic [7:0] close_of(input t_kind kind);
        logic [7:0] c;
        unique case (kind)
            KIND_ROUND:  c = CH_CLOSE_ROUND;
            KIND_SQUARE: c = CH_CLOSE_SQUARE;
            KIND_CURLY:  c = CH_CLOSE_CURLY;
            KIND_ANGLE:  c = CH_CLOSE_ANGLE;
            default:     c = CH_CLOSE_ROUND;
        endcase
        return c;
    endfunction

endpackage

@@ hw/rtl/qbm_if.sv @@
interface qbm_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_byte;
    logic       last;

    modport source (output valid, output char_byte, output last, input ready);
    modport sink   (input valid, input char_byte, input last, output ready);
endinterface

interface qbm_result_if #(
    parameter int INDEX_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic                   found;
    logic [INDEX_WIDTH-1:0] match_position;

    modport source (output valid, output found, output match_position, input ready);
    modport sink   (input valid, input found, input match_position, output ready);
endinterface

interface qbm_cfg_if #(
    parameter int INDEX_WIDTH = 16
);
    logic                   valid;
    logic                   ready;
    logic [INDEX_WIDTH-1:0] start_position;

    modport source (output valid, output start_position, input ready);
    modport sink   (input valid, input start_position, output ready);
endinterface

@@ hw/rtl/quoted_bracket_matcher.sv @@
// Quoted bracket matcher.
// i_req carries message bytes (char_byte, last), one request per byte, the
// first byte of each message at index 0. o_res carries at most one result
// per message: found and match_position (0 when not found). i_cfg writes
// start_position, the index of the opening bracket; write it only while the
// block is idle. i_cfg is always ready.
// A result is registered and appears on o_res in the cycle after the byte
// that causes it is accepted. Throughput: one byte per cycle while o_res
// is not stalling; the per-byte update is a single pass through the byte
// compare and depth logic into the state and result registers.
// Stall: the result register holds its request while o_res.ready is low; a
// new byte is still taken while the result register is empty or is being
// drained in the same cycle, so i_req.ready = !o_res.valid | o_res.ready.
// Reset (synchronous, i_rst_n low): start_position returns to 0, message
// state clears to waiting-for-start, and the result register empties.
// After the byte marked last the message state clears for the next message.
module quoted_bracket_matcher #(
    parameter int INDEX_WIDTH = 16
) (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    qbm_byte_if.sink                i_req,
    qbm_result_if.source            o_res,
    qbm_cfg_if.sink                 i_cfg
);

    localparam logic [INDEX_WIDTH-1:0] IDX_MAX = {INDEX_WIDTH{1'b1}};

    // Configuration
    logic [INDEX_WIDTH-1:0] r_start;

    // Message state
    logic [INDEX_WIDTH-1:0] r_idx,   n_idx;
    logic [INDEX_WIDTH-1:0] r_depth, n_depth;
    logic                   r_inq,   n_inq;
    logic                   r_qsgl,  n_qsgl;
    logic                   r_bs,    n_bs;
    qbm_pkg::t_kind         r_kind,  n_kind;
    qbm_pkg::t_phase        r_phase, n_phase;

    // Result register
    logic                   r_out_valid;
    logic                   r_found;
    logic [INDEX_WIDTH-1:0] r_pos;

    // Per-byte decode
    logic                   w_acc;
    logic [7:0]             w_c;
    logic                   w_hit;      // match or bad start on this byte
    logic                   w_hit_found;
    logic                   w_emit;
    logic                   w_is_quote;
    logic                   w_is_single;
    logic                   w_open_ok;
    qbm_pkg::t_kind         w_open_kind;
    qbm_pkg::t_phase        w_scan_phase; // phase after the byte, before end handling

    assign i_cfg.ready = 1'b1;
    assign i_req.ready = !r_out_valid || o_res.ready;
    assign w_acc       = i_req.valid && i_req.ready;
    assign w_c         = i_req.char_byte;

    assign o_res.valid          = r_out_valid;
    assign o_res.found          = r_found;
    assign o_res.match_position = r_pos;

    assign w_is_quote  = (w_c == qbm_pkg::CH_DQUOTE) || (w_c == qbm_pkg::CH_SQUOTE);
    assign w_is_single = (w_c == qbm_pkg::CH_SQUOTE);

    // Classify the byte as an opening bracket of some kind
    always_comb begin
        w_open_ok   = 1'b1;
        w_open_kind = qbm_pkg::KIND_ROUND;
        unique case (w_c)
            qbm_pkg::CH_OPEN_ROUND:  w_open_kind = qbm_pkg::KIND_ROUND;
            qbm_pkg::CH_OPEN_SQUARE: w_open_kind = qbm_pkg::KIND_SQUARE;
            qbm_pkg::CH_OPEN_CURLY:  w_open_kind = qbm_pkg::KIND_CURLY;
            qbm_pkg::CH_OPEN_ANGLE:  w_open_kind = qbm_pkg::KIND_ANGLE;
            default:                 w_open_ok   = 1'b0;
        endcase
    end

    // Next state: scan step, then end-of-message and index handling
    always_comb begin
        n_depth      = r_depth;
        n_inq        = r_inq;
        n_qsgl       = r_qsgl;
        n_kind       = r_kind;
        w_scan_phase = r_phase;
        w_hit        = 1'b0;
        w_hit_found  = 1'b0;

        unique case (r_phase)
            qbm_pkg::PH_WAIT: begin
                if (r_idx == r_start) begin
                    if (!w_open_ok) begin
                        // Not a bracket at start: report not found now
                        w_hit        = 1'b1;
                        w_scan_phase = qbm_pkg::PH_DONE;
                    end else begin
                        n_kind       = w_open_kind;
                        n_depth      = {{(INDEX_WIDTH-1){1'b0}}, 1'b1};
                        n_inq        = 1'b0;
                        n_qsgl       = 1'b0;
                        w_scan_phase = qbm_pkg::PH_SCAN;
                    end
                end
            end
            qbm_pkg::PH_SCAN: begin
                if (w_is_quote) begin
                    if (!r_bs) begin
                        if (!r_inq) begin
                            n_inq  = 1'b1;
                            n_qsgl = w_is_single;
                        end else if (r_qsgl == w_is_single) begin
                            n_inq  = 1'b0;
                            n_qsgl = 1'b0;
                        end
                    end
                end else if (w_c == qbm_pkg::open_of(r_kind)) begin
                    if (!r_inq && !r_bs && r_depth != IDX_MAX) begin
                        n_depth = r_depth + {{(INDEX_WIDTH-1){1'b0}}, 1'b1};
                    end
                end else if (w_c == qbm_pkg::close_of(r_kind)) begin
                    if (!r_inq && !r_bs && r_depth != '0) begin
                        n_depth = r_depth - {{(INDEX_WIDTH-1){1'b0}}, 1'b1};
                        if (r_depth == {{(INDEX_WIDTH-1){1'b0}}, 1'b1}) begin
                            w_hit        = 1'b1;
                            w_hit_found  = 1'b1;
                            w_scan_phase = qbm_pkg::PH_DONE;
                        end
                    end
                end
            end
            default: ;
        endcase

        n_bs    = (w_c == qbm_pkg::CH_BACKSLASH);
        n_phase = w_scan_phase;
        n_idx   = r_idx + {{(INDEX_WIDTH-1){1'b0}}, 1'b1};

        if (i_req.last) begin
            // Clear for the next message
            n_idx   = '0;
            n_depth = '0;
            n_inq   = 1'b0;
            n_qsgl  = 1'b0;
            n_bs    = 1'b0;
            n_kind  = qbm_pkg::KIND_ROUND;
            n_phase = qbm_pkg::PH_WAIT;
        end else if (r_idx == IDX_MAX) begin
            // Message too long: hold the index and stop scanning
            n_idx   = IDX_MAX;
            n_phase = qbm_pkg::PH_DONE;
        end
    end

    // Result: a hit, or a message end/overflow with no result given yet
    always_comb begin
        w_emit = w_hit ||
                 ((i_req.last || r_idx == IDX_MAX) && w_scan_phase != qbm_pkg::PH_DONE);
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_start     <= '0;
            r_idx       <= '0;
            r_depth     <= '0;
            r_inq       <= 1'b0;
            r_qsgl      <= 1'b0;
            r_bs        <= 1'b0;
            r_kind      <= qbm_pkg::KIND_ROUND;
            r_phase     <= qbm_pkg::PH_WAIT;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cfg.valid) begin
                r_start <= i_cfg.start_position;
            end
            if (w_acc) begin
                r_idx   <= n_idx;
                r_depth <= n_depth;
                r_inq   <= n_inq;
                r_qsgl  <= n_qsgl;
                r_bs    <= n_bs;
                r_kind  <= n_kind;
                r_phase <= n_phase;
            end
            // Drop the taken result, load a new one from this byte
            if (w_acc) begin
                r_out_valid <= w_emit;
            end else if (o_res.ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Result payload, loaded with its valid bit
    always_ff @(posedge i_clk) begin
        if (w_acc && w_emit) begin
            r_found <= w_hit_found;
            r_pos   <= w_hit_found ? r_idx : '0;
        end
    end

endmodule

@@ hw/rtl/qbm_checker.sv @@
module qbm_checker #(
    parameter int INDEX_WIDTH = 16
) (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   i_in_valid,
    input logic                   i_in_ready,
    input logic                   i_out_valid,
    input logic                   i_out_ready,
    input logic                   i_found,
    input logic [INDEX_WIDTH-1:0] i_match_position
);

`include "quoted_bracket_matcher_assert.svh"

    `QBM_ASSERT_NOW(a_notfound_pos_zero, i_out_valid && !i_found, i_match_position == '0, "not-found result with nonzero position")
    `QBM_ASSERT_NOW(a_ready_when_empty, !i_out_valid, i_in_ready, "input stalled while result register empty")
    `QBM_ASSERT_NOW(a_result_from_byte, $rose(i_out_valid), $past(i_in_valid && i_in_ready), "result without an accepted byte")
    `QBM_ASSERT_NEXT(a_stall_holds, i_out_valid && !i_out_ready, i_out_valid && $stable(i_found) && $stable(i_match_position), "stalled result changed")

endmodule

bind quoted_bracket_matcher qbm_checker #(
    .INDEX_WIDTH(INDEX_WIDTH)
) u_qbm_checker (
    .i_clk            (i_clk),
    .i_rst_n          (i_rst_n),
    .i_in_valid       (i_req.valid),
    .i_in_ready       (i_req.ready),
    .i_out_valid      (o_res.valid),
    .i_out_ready      (o_res.ready),
    .i_found          (o_res.found),
    .i_match_position (o_res.match_position)
);

@@ tb/quoted_bracket_matcher_tb.sv @@
`timescale 1ns / 1ps

module quoted_bracket_matcher_tb;

    localparam int IW       = 16;
    localparam int HALF_PER = 6;

    typedef struct packed {
        logic [7:0] ch;
        logic       last;
    } byte_req_t;

    typedef struct packed {
        logic          found;
        logic [IW-1:0] pos;
    } match_t;

    logic i_clk;
    logic i_rst_n;

    qbm_byte_if                          req_if ();
    qbm_result_if #(.INDEX_WIDTH(IW))    res_if ();
    qbm_cfg_if    #(.INDEX_WIDTH(IW))    cfg_if ();

    quoted_bracket_matcher #(
        .INDEX_WIDTH(IW)
    ) dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (req_if.sink),
        .o_res   (res_if.source),
        .i_cfg   (cfg_if.sink)
    );

    // Pending byte requests, the message under construction, and the
    // bracket matches still owed by the block.
    byte_req_t  byte_q[$];
    logic [7:0] msg_buf[$];
    match_t     match_q[$];

    // Traffic shaping, set by the sequencer, read by driver and monitor.
    int gap_pct        = 24;
    bit hold_sender    = 1'b0;
    bit arm_long_stall = 1'b0;
    bit long_stall_done = 1'b0;
    int stall_left     = 0;
    int err_count      = 0;

    // Matcher state as the testbench sees it.
    logic [IW-1:0]   start_pos = '0;
    logic [IW-1:0]   byte_idx  = '0;
    logic [IW-1:0]   depth     = '0;
    logic            in_text   = 1'b0;
    logic            is_sq     = 1'b0;
    logic            prev_bs   = 1'b0;
    qbm_pkg::t_kind  br_kind   = qbm_pkg::KIND_ROUND;
    qbm_pkg::t_phase scan_ph   = qbm_pkg::PH_WAIT;

    match_t exp_res;
    match_t want;

    initial begin
        i_clk = 1'b0;
        forever #(HALF_PER) i_clk = ~i_clk;
    end

    // Hard limit on the run, far beyond the slowest legal run.
    initial begin
        #20000000;
        $display("** quoted_bracket_matcher: FAILED **");
        $finish;
    end

    // Advance the matcher state by one byte; return 1 when the byte owes a
    // result, with the result in res.
    function automatic bit predict_match(input logic [7:0] c, input logic is_last,
                                         output match_t res);
        bit         got;
        bit         esc;
        bit         single;
        logic [7:0] op_ch;
        logic [7:0] cl_ch;
        got = 1'b0;
        res = '0;
        case (scan_ph)
            qbm_pkg::PH_WAIT: begin
                if (byte_idx == start_pos) begin
                    case (c)
                        qbm_pkg::CH_OPEN_ROUND:  br_kind = qbm_pkg::KIND_ROUND;
                        qbm_pkg::CH_OPEN_SQUARE: br_kind = qbm_pkg::KIND_SQUARE;
                        qbm_pkg::CH_OPEN_CURLY:  br_kind = qbm_pkg::KIND_CURLY;
                        qbm_pkg::CH_OPEN_ANGLE:  br_kind = qbm_pkg::KIND_ANGLE;
                        default:                 got = 1'b1;
                    endcase
                    // Anything but an opening bracket at the start: not found now.
                    if (got) begin
                        scan_ph = qbm_pkg::PH_DONE;
                    end else begin
                        depth   = IW'(1);
                        in_text = 1'b0;
                        is_sq   = 1'b0;
                        scan_ph = qbm_pkg::PH_SCAN;
                    end
                end
            end
            qbm_pkg::PH_SCAN: begin
                esc = prev_bs;
                case (br_kind)
                    qbm_pkg::KIND_ROUND: begin
                        op_ch = qbm_pkg::CH_OPEN_ROUND;
                        cl_ch = qbm_pkg::CH_CLOSE_ROUND;
                    end
                    qbm_pkg::KIND_SQUARE: begin
                        op_ch = qbm_pkg::CH_OPEN_SQUARE;
                        cl_ch = qbm_pkg::CH_CLOSE_SQUARE;
                    end
                    qbm_pkg::KIND_CURLY: begin
                        op_ch = qbm_pkg::CH_OPEN_CURLY;
                        cl_ch = qbm_pkg::CH_CLOSE_CURLY;
                    end
                    default: begin
                        op_ch = qbm_pkg::CH_OPEN_ANGLE;
                        cl_ch = qbm_pkg::CH_CLOSE_ANGLE;
                    end
                endcase
                if (c == qbm_pkg::CH_DQUOTE || c == qbm_pkg::CH_SQUOTE) begin
                    single = (c == qbm_pkg::CH_SQUOTE);
                    if (!esc) begin
                        if (!in_text) begin
                            in_text = 1'b1;
                            is_sq   = single;
                        end else if (is_sq == single) begin
                            in_text = 1'b0;
                            is_sq   = 1'b0;
                        end
                    end
                end else if (c == op_ch) begin
                    // Depth saturates at its top value.
                    if (!in_text && !esc && depth != '1)
                        depth = depth + 1'b1;
                end else if (c == cl_ch) begin
                    if (!in_text && !esc && depth != '0) begin
                        depth = depth - 1'b1;
                        if (depth == '0) begin
                            got       = 1'b1;
                            res.found = 1'b1;
                            res.pos   = byte_idx;
                            scan_ph   = qbm_pkg::PH_DONE;
                        end
                    end
                end
            end
            default: ;
        endcase
        // Escape looks at the raw previous byte, escaped or not.
        prev_bs = (c == qbm_pkg::CH_BACKSLASH);

        if (is_last) begin
            if (!got && scan_ph != qbm_pkg::PH_DONE)
                got = 1'b1;
            byte_idx = '0;
            depth    = '0;
            in_text  = 1'b0;
            is_sq    = 1'b0;
            prev_bs  = 1'b0;
            br_kind  = qbm_pkg::KIND_ROUND;
            scan_ph  = qbm_pkg::PH_WAIT;
            return got;
        end

        // Message too long: give up at the top index and hold there.
        if (byte_idx == '1) begin
            if (!got && scan_ph != qbm_pkg::PH_DONE)
                got = 1'b1;
            scan_ph = qbm_pkg::PH_DONE;
        end else begin
            byte_idx = byte_idx + 1'b1;
        end
        return got;
    endfunction

    // Driver: retire the accepted request into the predictor, then present
    // the next pending byte unless idling or held.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            req_if.valid <= 1'b0;
        end else begin
            if (req_if.valid && req_if.ready) begin
                if (predict_match(req_if.char_byte, req_if.last, exp_res))
                    match_q.push_back(exp_res);
            end
            if (!req_if.valid || req_if.ready) begin
                if (byte_q.size() != 0 && !hold_sender &&
                    $urandom_range(0, 99) >= gap_pct) begin
                    req_if.valid     <= 1'b1;
                    req_if.char_byte <= byte_q[0].ch;
                    req_if.last      <= byte_q[0].last;
                    void'(byte_q.pop_front());
                end else begin
                    req_if.valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each accepted result against the oldest expected
    // match, then pick the next ready, honoring a long hold-off once.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            res_if.ready <= 1'b0;
        end else begin
            if (res_if.valid && res_if.ready) begin
                if (match_q.size() == 0) begin
                    err_count++;
                    $display("%0t: unexpected result: expected none, got found=%0b pos=%0d",
                             $time, res_if.found, res_if.match_position);
                end else begin
                    want = match_q.pop_front();
                    if (res_if.found !== want.found) begin
                        err_count++;
                        $display("%0t: found mismatch: expected %0b, got %0b",
                                 $time, want.found, res_if.found);
                    end
                    if (res_if.match_position !== want.pos) begin
                        err_count++;
                        $display("%0t: match_position mismatch: expected %0d, got %0d",
                                 $time, want.pos, res_if.match_position);
                    end
                end
            end
            if (arm_long_stall && !long_stall_done) begin
                stall_left      = 400;
                long_stall_done = 1'b1;
            end
            if (stall_left > 0) begin
                stall_left--;
                res_if.ready <= 1'b0;
            end else begin
                res_if.ready <= ($urandom_range(0, 99) >= gap_pct);
            end
        end
    end

    function automatic void put(input logic [7:0] c);
        msg_buf.push_back(c);
    endfunction

    function automatic void put_str(input string s);
        for (int i = 0; i < s.len(); i++)
            msg_buf.push_back(s[i]);
    endfunction

    // Move the built message to the pending queue, marking its final byte.
    function automatic void end_msg();
        for (int i = 0; i < msg_buf.size(); i++)
            byte_q.push_back('{ch: msg_buf[i], last: (i == msg_buf.size() - 1)});
        msg_buf.delete();
    endfunction

    function automatic logic [7:0] letter();
        return 8'h61 + 8'($urandom_range(0, 25));
    endfunction

    // Noise byte, heavy on brackets, quotes and backslashes.
    function automatic logic [7:0] noise_char(input logic [7:0] op_ch,
                                              input logic [7:0] cl_ch);
        logic [7:0] c;
        case ($urandom_range(0, 9))
            0: c = op_ch;
            1: c = cl_ch;
            2: c = qbm_pkg::CH_DQUOTE;
            3: c = qbm_pkg::CH_SQUOTE;
            4: c = qbm_pkg::CH_BACKSLASH;
            5: begin
                case ($urandom_range(0, 7))
                    0: c = qbm_pkg::CH_OPEN_ROUND;
                    1: c = qbm_pkg::CH_CLOSE_ROUND;
                    2: c = qbm_pkg::CH_OPEN_SQUARE;
                    3: c = qbm_pkg::CH_CLOSE_SQUARE;
                    4: c = qbm_pkg::CH_OPEN_CURLY;
                    5: c = qbm_pkg::CH_CLOSE_CURLY;
                    6: c = qbm_pkg::CH_OPEN_ANGLE;
                    default: c = qbm_pkg::CH_CLOSE_ANGLE;
                endcase
            end
            default: c = 8'($urandom_range(0, 255));
        endcase
        return c;
    endfunction

    // Build one random message for the given start index; return the
    // number of bytes that the matcher actually looks at.
    function automatic int gen_message(input int start);
        int         mode;
        int         pre;
        int         lvl;
        int         budget;
        int         n;
        logic [7:0] op_ch;
        logic [7:0] cl_ch;
        logic [7:0] q;
        logic [7:0] oq;
        case ($urandom_range(0, 3))
            0: begin
                op_ch = qbm_pkg::CH_OPEN_ROUND;
                cl_ch = qbm_pkg::CH_CLOSE_ROUND;
            end
            1: begin
                op_ch = qbm_pkg::CH_OPEN_SQUARE;
                cl_ch = qbm_pkg::CH_CLOSE_SQUARE;
            end
            2: begin
                op_ch = qbm_pkg::CH_OPEN_CURLY;
                cl_ch = qbm_pkg::CH_CLOSE_CURLY;
            end
            default: begin
                op_ch = qbm_pkg::CH_OPEN_ANGLE;
                cl_ch = qbm_pkg::CH_CLOSE_ANGLE;
            end
        endcase
        mode = $urandom_range(0, 99);
        pre  = start;
        // Short message: end before the start index is reached.
        if (mode < 8 && start > 0)
            pre = $urandom_range(1, start);
        for (int i = 0; i < pre; i++)
            put(8'($urandom_range(0, 255)));
        if (mode < 8 && start > 0) begin
            end_msg();
            return 1;
        end

        if (mode < 16) begin
            // Start byte that is no bracket.
            put(letter());
            n = $urandom_range(0, 4);
            for (int i = 0; i < n; i++)
                put(noise_char(op_ch, cl_ch));
        end else if (mode < 30) begin
            put(op_ch);
            n = $urandom_range(0, 20);
            for (int i = 0; i < n; i++)
                put(noise_char(op_ch, cl_ch));
        end else begin
            // Nested brackets with quoted runs and escapes, closed in most messages.
            put(op_ch);
            lvl    = 1;
            budget = $urandom_range(0, 24);
            for (int t = 0; t < budget; t++) begin
                case ($urandom_range(0, 9))
                    0, 1: begin
                        put(op_ch);
                        lvl++;
                    end
                    2, 3: begin
                        if (lvl > 1) begin
                            put(cl_ch);
                            lvl--;
                        end
                    end
                    4: begin
                        q  = $urandom_range(0, 1) ? qbm_pkg::CH_DQUOTE : qbm_pkg::CH_SQUOTE;
                        oq = (q == qbm_pkg::CH_DQUOTE) ? qbm_pkg::CH_SQUOTE
                                                       : qbm_pkg::CH_DQUOTE;
                        put(q);
                        n = $urandom_range(0, 5);
                        for (int i = 0; i < n; i++) begin
                            case ($urandom_range(0, 4))
                                0: put(op_ch);
                                1: put(cl_ch);
                                2: put(oq);
                                3: begin
                                    put(qbm_pkg::CH_BACKSLASH);
                                    put(q);
                                end
                                default: put(letter());
                            endcase
                        end
                        put(q);
                    end
                    5: begin
                        put(qbm_pkg::CH_BACKSLASH);
                        if ($urandom_range(0, 3) == 0)
                            put(qbm_pkg::CH_BACKSLASH);
                        case ($urandom_range(0, 3))
                            0: put(op_ch);
                            1: put(cl_ch);
                            2: put(qbm_pkg::CH_DQUOTE);
                            default: put(qbm_pkg::CH_SQUOTE);
                        endcase
                    end
                    6: put(noise_char(op_ch, cl_ch));
                    default: put(letter());
                endcase
            end
            if ($urandom_range(0, 99) < 80) begin
                while (lvl > 0) begin
                    put(cl_ch);
                    lvl--;
                end
            end
            n = $urandom_range(0, 3);
            for (int i = 0; i < n; i++)
                put(letter());
        end
        n = msg_buf.size() - pre;
        end_msg();
        return n;
    endfunction

    function automatic void gen_phase(input int start, input int target);
        int made;
        made = 0;
        while (made < target)
            made += gen_message(start);
    endfunction

    // Write start_position; the register takes it on the valid/ready edge.
    task automatic write_start(input logic [IW-1:0] v);
        @(posedge i_clk);
        cfg_if.valid          <= 1'b1;
        cfg_if.start_position <= v;
        do @(posedge i_clk); while (!cfg_if.ready);
        cfg_if.valid <= 1'b0;
        start_pos = v;
    endtask

    // Drain all pending requests and owed matches, then let the pipeline
    // settle so that a byte with no result is also through.
    task automatic settle();
        int waited;
        waited = 0;
        while (byte_q.size() != 0 || req_if.valid)
            @(posedge i_clk);
        while (match_q.size() != 0 && waited < 3000) begin
            @(posedge i_clk);
            waited++;
        end
        if (match_q.size() != 0) begin
            err_count++;
            $display("%0t: missing results: expected %0d more, got none",
                     $time, match_q.size());
            match_q.delete();
        end
        repeat (4) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n               = 1'b0;
        req_if.valid          = 1'b0;
        req_if.char_byte      = '0;
        req_if.last           = 1'b0;
        res_if.ready          = 1'b0;
        cfg_if.valid          = 1'b0;
        cfg_if.start_position = '0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: every bracket kind, start byte not a bracket, a single-quoted
        // run with a double quote inside, an escaped backslash, and a
        // last byte that comes before the match.
        write_start('0);
        put_str("()");       end_msg();
        put_str("[a]");      end_msg();
        put_str("{<}");      end_msg();
        put_str("<>");       end_msg();
        put_str("x(");       end_msg();
        put_str("('\")')");  end_msg();
        put_str("(\\\\))");  end_msg();
        put_str("((");       end_msg();
        settle();

        // Top start index: a short message that never reaches the start.
        write_start('1);
        put_str("()");
        end_msg();
        settle();

        // Random phases.
        gap_pct = 24;
        write_start(IW'(3));
        gen_phase(3, 120);
        // Hold the result side off for a long stretch while bytes keep coming.
        arm_long_stall = 1'b1;
        settle();

        gap_pct = 0;
        write_start('0);
        gen_phase(0, 120);
        settle();

        gap_pct = 24;
        write_start(IW'(1));
        gen_phase(1, 60);
        while (byte_q.size() != 0)
            @(posedge i_clk);
        // Pause the sender until every owed match is back.
        hold_sender = 1'b1;
        gen_phase(1, 60);
        while (req_if.valid || match_q.size() != 0)
            @(posedge i_clk);
        repeat (20) @(posedge i_clk);
        hold_sender = 1'b0;
        settle();

        write_start(IW'(7));
        gen_phase(7, 120);
        settle();

        begin
            int s;
            s = $urandom_range(0, 10);
            write_start(IW'(s));
            gen_phase(s, 120);
        end
        settle();

        write_start(IW'(2));
        gen_phase(2, 120);
        settle();

        repeat (8) @(posedge i_clk);
        if (err_count == 0) begin
            $display("** quoted_bracket_matcher: PASSED **");
        end else begin
            $display("** quoted_bracket_matcher: FAILED **");
        end
        $finish;
    end

endmodule
